@@ rtl/core/twist_to_four_wheel_commands_core_defines.svh @@
// Assertion macros for the bound checker in tw4w_checker.sv.
`ifndef TWIST_TO_FOUR_WHEEL_COMMANDS_CORE_DEFINES_SVH
`define TWIST_TO_FOUR_WHEEL_COMMANDS_CORE_DEFINES_SVH

// Clocked assertion with reset disable.
`define TW4W_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form: antecedent, consequent.
`define TW4W_ASSERT_IMPL(label, ante, cons, msg) \
	`TW4W_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication form.
`define TW4W_ASSERT_NEXT(label, ante, cons, msg) \
	`TW4W_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/core/tw4w_pkg.sv @@
package tw4w_pkg;

	localparam int IN_W = 24;
	localparam int THR_W = 23;
	localparam int RAD_W = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 23;

	localparam int TAB_LEN = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CX_W = 28;
	localparam int CZ_W = 20;
	localparam int HALF_PI_Q16 = 102944;
	localparam int GAIN_INV = 39797;

	localparam int DIV_STEPS = 16;
	localparam int Q_W = DIV_STEPS + 1;
	localparam int SUM_W = 25;
	localparam int REM_W = SUM_W + 1;

	localparam int SAT_W = 68;
	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	localparam logic [THR_W-1:0] THR_RESET = 23'd655;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAD_FL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAD_FR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAD_RL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAD_RR   = 3'd5;

	typedef struct packed {
		logic signed [IN_W-1:0] forward_speed;
		logic signed [IN_W-1:0] lateral_speed;
		logic signed [IN_W-1:0] yaw_rate;
	} in_t;

	typedef struct packed {
		logic signed [IN_W-1:0] velocity_front_left;
		logic signed [IN_W-1:0] velocity_front_right;
		logic signed [IN_W-1:0] velocity_rear_left;
		logic signed [IN_W-1:0] velocity_rear_right;
		logic signed [IN_W-1:0] steer_front_left;
		logic signed [IN_W-1:0] steer_front_right;
		logic signed [IN_W-1:0] steer_rear_left;
		logic signed [IN_W-1:0] steer_rear_right;
	} out_t;

	// rotation steps actually run
	function automatic int rot_steps(int steps);
		return (steps < TAB_LEN) ? steps : TAB_LEN;
	endfunction

	// stages in the rotate/divide chain: divider needs one setup plus one per bit
	function automatic int chain_len(int steps);
		return (rot_steps(steps) > Q_W) ? rot_steps(steps) : Q_W;
	endfunction

	// atan(2^-i) in Q.16
	function automatic logic signed [CZ_W-1:0] atan_q16(int i);
		logic signed [CZ_W-1:0] r;
		case (i)
			0:  r = 20'sd51472;
			1:  r = 20'sd30385;
			2:  r = 20'sd16055;
			3:  r = 20'sd8150;
			4:  r = 20'sd4091;
			5:  r = 20'sd2047;
			6:  r = 20'sd1024;
			7:  r = 20'sd512;
			8:  r = 20'sd256;
			9:  r = 20'sd128;
			10: r = 20'sd64;
			11: r = 20'sd32;
			12: r = 20'sd16;
			13: r = 20'sd8;
			14: r = 20'sd4;
			15: r = 20'sd2;
			16: r = 20'sd1;
			default: r = 20'sd0;
		endcase
		return r;
	endfunction

	// clamp to the output range
	function automatic logic signed [IN_W-1:0] sat(logic signed [SAT_W-1:0] v);
		logic signed [IN_W-1:0] r;
		if (v > SAT_W'(OUT_MAX)) r = IN_W'(OUT_MAX);
		else if (v < SAT_W'(OUT_MIN)) r = IN_W'(OUT_MIN);
		else r = v[IN_W-1:0];
		return r;
	endfunction

endpackage

@@ rtl/core/twist_to_four_wheel_commands_core.sv @@
// Channel  Handshake              Payload
// -------  ---------------------  -------------------------------
// in       in_valid / in_ready    in_data  (tw4w_pkg::in_t)
// out      out_valid / out_ready  out_data (tw4w_pkg::out_t)
// cfg      cfg_we                 cfg_addr, cfg_wdata
//
// Items pass the stage 1 register, the rotation and quotient-bit chain and
// stages 2 to 5; one item can enter every cycle while the pipeline is not held.
// The whole pipeline advances together and holds when the output register
// is full and not taken; in_ready follows from that.
// Reset clears valid bits and loads the register reset values.
module twist_to_four_wheel_commands_core #(
	parameter int CORDIC_STEPS = tw4w_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  tw4w_pkg::in_t                          in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output tw4w_pkg::out_t                         out_data,
	input  logic                                   cfg_we,
	input  logic [tw4w_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [tw4w_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	localparam int LEN = tw4w_pkg::chain_len(CORDIC_STEPS);
	localparam int IW = tw4w_pkg::IN_W;
	localparam int CXW = tw4w_pkg::CX_W;
	localparam int CZW = tw4w_pkg::CZ_W;
	localparam int QW = tw4w_pkg::Q_W;
	localparam int SW = tw4w_pkg::SUM_W;
	localparam int WR_W = IW + tw4w_pkg::RAD_W + 1;
	localparam int HP_W = CXW + 18;
	localparam int HY_W = HP_W - 16;
	localparam int WRA_W = WR_W + QW + 1;
	localparam int AL_W = CZW + QW + 1;
	localparam int WA_W = IW + QW + 1;
	localparam int HL_W = HY_W + QW + 1;
	localparam int VS_W = 66;
	localparam int FS_W = 44;

	typedef enum logic [1:0] {MODE_ZERO, MODE_BOTH, MODE_LIN, MODE_ROT} mode_t;

	logic en;
	logic [tw4w_pkg::THR_W-1:0] move_thr_q, rot_thr_q;
	logic [tw4w_pkg::RAD_W-1:0] rad_q [4];

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_thr_q <= tw4w_pkg::THR_RESET;
			rot_thr_q <= tw4w_pkg::THR_RESET;
			for (int i = 0; i < 4; i++) rad_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tw4w_pkg::REG_MOVE_THR: move_thr_q <= cfg_wdata;
				tw4w_pkg::REG_ROT_THR:  rot_thr_q <= cfg_wdata;
				tw4w_pkg::REG_RAD_FL:   rad_q[0] <= cfg_wdata[tw4w_pkg::RAD_W-1:0];
				tw4w_pkg::REG_RAD_FR:   rad_q[1] <= cfg_wdata[tw4w_pkg::RAD_W-1:0];
				tw4w_pkg::REG_RAD_RL:   rad_q[2] <= cfg_wdata[tw4w_pkg::RAD_W-1:0];
				tw4w_pkg::REG_RAD_RR:   rad_q[3] <= cfg_wdata[tw4w_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: magnitudes, case select, quadrant fold
	logic [IW-1:0] ax, ay, aw;
	logic [SW-1:0] mv, sum;
	mode_t mode;
	logic signed [CXW-1:0] xe, ye, x0, y0;
	logic signed [CZW-1:0] z0;

	always_comb begin
		ax = in_data.forward_speed[IW-1] ? IW'(-in_data.forward_speed)
			: IW'(in_data.forward_speed);
		ay = in_data.lateral_speed[IW-1] ? IW'(-in_data.lateral_speed)
			: IW'(in_data.lateral_speed);
		aw = in_data.yaw_rate[IW-1] ? IW'(-in_data.yaw_rate) : IW'(in_data.yaw_rate);
		mv = SW'(ax) + SW'(ay);
		sum = mv + SW'(aw);
		if (mv < SW'(move_thr_q) && aw < IW'(rot_thr_q)) mode = MODE_ZERO;
		else if (mv > SW'(move_thr_q) && aw > IW'(rot_thr_q)) mode = MODE_BOTH;
		else if (mv > SW'(move_thr_q)) mode = MODE_LIN;
		else mode = MODE_ROT;
		xe = CXW'(in_data.forward_speed);
		ye = CXW'(in_data.lateral_speed);
		if (xe < 0 && ye >= 0) begin
			x0 = ye; y0 = -xe; z0 = CZW'(tw4w_pkg::HALF_PI_Q16);
		end else if (xe < 0) begin
			x0 = -ye; y0 = xe; z0 = -CZW'(tw4w_pkg::HALF_PI_Q16);
		end else begin
			x0 = xe; y0 = ye; z0 = '0;
		end
	end

	logic v_s1;
	logic signed [CXW-1:0] x_s1, y_s1;
	logic signed [CZW-1:0] z_s1;
	logic [SW-1:0] mv_s1, sum_s1;
	logic signed [IW-1:0] w_s1;
	mode_t mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x0; y_s1 <= y0; z_s1 <= z0;
			mv_s1 <= mv; sum_s1 <= sum;
			w_s1 <= in_data.yaw_rate; mode_s1 <= mode;
		end
	end

	// rotation and ratio chain
	logic v_c;
	logic signed [CXW-1:0] x_c;
	logic signed [CZW-1:0] z_c;
	logic [QW-1:0] q_c;
	logic rnz_c;

	tw4w_vecdiv #(.STEPS(CORDIC_STEPS)) u_vecdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.x0(x_s1), .y0(y_s1), .z0(z_s1), .num(mv_s1), .den(sum_s1),
		.out_valid(v_c), .x_out(x_c), .z_out(z_c), .quot(q_c), .rem_nz(rnz_c)
	);

	// carry yaw and case alongside the chain
	logic signed [IW-1:0] sbw_s [LEN+1];
	mode_t sbm_s [LEN+1];
	assign sbw_s[0] = w_s1;
	assign sbm_s[0] = mode_s1;
	for (genvar k = 0; k < LEN; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sbw_s[k+1] <= sbw_s[k];
				sbm_s[k+1] <= sbm_s[k];
			end
		end
	end

	// stage 2: gain product, ratios, yaw times radius
	logic v_s2;
	logic signed [HP_W-1:0] hp_s2;
	logic [QW-1:0] lr_s2, ar_s2;
	logic signed [WR_W-1:0] wr_s2 [4];
	logic signed [CZW-1:0] z_s2;
	logic signed [IW-1:0] w_s2;
	mode_t mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hp_s2 <= HP_W'(x_c) * HP_W'($signed(18'(tw4w_pkg::GAIN_INV)));
			lr_s2 <= q_c;
			ar_s2 <= QW'(QW'(1 << 16) - q_c - QW'(rnz_c));
			for (int i = 0; i < 4; i++)
				wr_s2[i] <= WR_W'(sbw_s[LEN]) * WR_W'($signed({1'b0, rad_q[i]}));
			z_s2 <= z_c;
			w_s2 <= sbw_s[LEN];
			mode_s2 <= sbm_s[LEN];
		end
	end

	// stage 3: rounded magnitude, ratio-weighted products
	logic v_s3;
	logic signed [HY_W-1:0] hy_s3;
	logic [QW-1:0] lr_s3;
	logic signed [WR_W-1:0] wr_s3 [4];
	logic signed [WRA_W-1:0] wra_s3 [4];
	logic signed [AL_W-1:0] al_s3;
	logic signed [WA_W-1:0] wa_s3;
	logic signed [CZW-1:0] z_s3;
	logic signed [IW-1:0] w_s3;
	mode_t mode_s3;
	logic signed [HP_W-1:0] hp_rnd;

	assign hp_rnd = hp_s2 + HP_W'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hy_s3 <= hp_rnd[HP_W-1:16];
			lr_s3 <= lr_s2;
			for (int i = 0; i < 4; i++) begin
				wr_s3[i] <= wr_s2[i];
				wra_s3[i] <= WRA_W'(wr_s2[i]) * WRA_W'($signed({1'b0, ar_s2}));
			end
			al_s3 <= AL_W'(z_s2) * AL_W'($signed({1'b0, lr_s2}));
			wa_s3 <= WA_W'(w_s2) * WA_W'($signed({1'b0, ar_s2}));
			z_s3 <= z_s2;
			w_s3 <= w_s2;
			mode_s3 <= mode_s2;
		end
	end

	// stage 4: magnitude times linear ratio, rounded steer blend
	logic v_s4;
	logic signed [HY_W-1:0] hy_s4;
	logic signed [HL_W-1:0] hl_s4;
	logic signed [WR_W-1:0] wr_s4 [4];
	logic signed [WRA_W-1:0] wra_s4 [4];
	logic signed [FS_W-1:0] fs_s4;
	logic signed [CZW-1:0] z_s4;
	logic signed [IW-1:0] w_s4;
	mode_t mode_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hy_s4 <= hy_s3;
			hl_s4 <= HL_W'(hy_s3) * HL_W'($signed({1'b0, lr_s3}));
			for (int i = 0; i < 4; i++) begin
				wr_s4[i] <= wr_s3[i];
				wra_s4[i] <= wra_s3[i];
			end
			fs_s4 <= FS_W'(al_s3) + FS_W'(wa_s3) + FS_W'(32768);
			z_s4 <= z_s3;
			w_s4 <= w_s3;
			mode_s4 <= mode_s3;
		end
	end

	// stage 5: round, select case, saturate into the output register
	logic signed [tw4w_pkg::SAT_W-1:0] vel [4];
	logic signed [tw4w_pkg::SAT_W-1:0] front;
	logic signed [VS_W-1:0] vsum [4];
	logic signed [WR_W-1:0] wrr [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			vsum[i] = (VS_W'(hl_s4) <<< 16) + VS_W'(wra_s4[i]) + VS_W'(64'sd2147483648);
			wrr[i] = wr_s4[i] + WR_W'(32768);
		end
		case (mode_s4)
			MODE_BOTH: begin
				for (int i = 0; i < 4; i++)
					vel[i] = tw4w_pkg::SAT_W'($signed(vsum[i][VS_W-1:32]));
				front = tw4w_pkg::SAT_W'($signed(fs_s4[FS_W-1:16]));
			end
			MODE_LIN: begin
				for (int i = 0; i < 4; i++) vel[i] = tw4w_pkg::SAT_W'(hy_s4);
				front = tw4w_pkg::SAT_W'(z_s4);
			end
			MODE_ROT: begin
				for (int i = 0; i < 4; i++)
					vel[i] = tw4w_pkg::SAT_W'($signed(wrr[i][WR_W-1:16]));
				front = tw4w_pkg::SAT_W'(w_s4);
			end
			default: begin
				for (int i = 0; i < 4; i++) vel[i] = '0;
				front = '0;
			end
		endcase
	end

	logic v_s5;
	tw4w_pkg::out_t out_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5.velocity_front_left <= tw4w_pkg::sat(vel[0]);
			out_s5.velocity_front_right <= tw4w_pkg::sat(vel[1]);
			out_s5.velocity_rear_left <= tw4w_pkg::sat(vel[2]);
			out_s5.velocity_rear_right <= tw4w_pkg::sat(vel[3]);
			out_s5.steer_front_left <= tw4w_pkg::sat(front);
			out_s5.steer_front_right <= tw4w_pkg::sat(front);
			out_s5.steer_rear_left <= tw4w_pkg::sat(-front);
			out_s5.steer_rear_right <= tw4w_pkg::sat(-front);
		end
	end

	assign out_valid = v_s5;
	assign out_data = out_s5;

endmodule

@@ rtl/core/tw4w_vecdiv.sv @@
module tw4w_vecdiv #(
	parameter int STEPS = tw4w_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [tw4w_pkg::CX_W-1:0]     x0,
	input  logic signed [tw4w_pkg::CX_W-1:0]     y0,
	input  logic signed [tw4w_pkg::CZ_W-1:0]     z0,
	input  logic        [tw4w_pkg::SUM_W-1:0]    num,
	input  logic        [tw4w_pkg::SUM_W-1:0]    den,
	output logic                                 out_valid,
	output logic signed [tw4w_pkg::CX_W-1:0]     x_out,
	output logic signed [tw4w_pkg::CZ_W-1:0]     z_out,
	output logic        [tw4w_pkg::Q_W-1:0]      quot,
	output logic                                 rem_nz
);
	localparam int NROT = tw4w_pkg::rot_steps(STEPS);
	localparam int LEN = tw4w_pkg::chain_len(STEPS);

	logic                              v_s [LEN+1];
	logic signed [tw4w_pkg::CX_W-1:0]  x_s [LEN+1];
	logic signed [tw4w_pkg::CX_W-1:0]  y_s [LEN+1];
	logic signed [tw4w_pkg::CZ_W-1:0]  z_s [LEN+1];
	logic        [tw4w_pkg::REM_W-1:0] r_s [LEN+1];
	logic        [tw4w_pkg::Q_W-1:0]   q_s [LEN+1];
	logic        [tw4w_pkg::SUM_W-1:0] d_s [LEN+1];

	assign v_s[0] = in_valid;
	assign x_s[0] = x0;
	assign y_s[0] = y0;
	assign z_s[0] = z0;
	assign r_s[0] = tw4w_pkg::REM_W'(num);
	assign q_s[0] = '0;
	assign d_s[0] = den;

	for (genvar k = 0; k < LEN; k++) begin : g_stage
		logic signed [tw4w_pkg::CX_W-1:0]  x_n, y_n;
		logic signed [tw4w_pkg::CZ_W-1:0]  z_n;
		logic        [tw4w_pkg::REM_W-1:0] r_n;
		logic        [tw4w_pkg::Q_W-1:0]   q_n;
		logic        [tw4w_pkg::REM_W:0]   r2;

		// one vectoring rotation toward y = 0
		if (k < NROT) begin : g_rot
			always_comb begin
				if (y_s[k] < 0) begin
					x_n = x_s[k] - (y_s[k] >>> k);
					y_n = y_s[k] + (x_s[k] >>> k);
					z_n = z_s[k] - tw4w_pkg::atan_q16(k);
				end else begin
					x_n = x_s[k] + (y_s[k] >>> k);
					y_n = y_s[k] - (x_s[k] >>> k);
					z_n = z_s[k] + tw4w_pkg::atan_q16(k);
				end
			end
		end else begin : g_rot_pass
			assign x_n = x_s[k];
			assign y_n = y_s[k];
			assign z_n = z_s[k];
		end

		// setup compare, then one quotient bit per stage
		if (k == 0) begin : g_div_init
			assign r2 = {1'b0, r_s[k]};
			always_comb begin
				if (r_s[k] >= tw4w_pkg::REM_W'(d_s[k])) begin
					r_n = r_s[k] - tw4w_pkg::REM_W'(d_s[k]);
					q_n = tw4w_pkg::Q_W'(1);
				end else begin
					r_n = r_s[k];
					q_n = '0;
				end
			end
		end else if (k < tw4w_pkg::Q_W) begin : g_div_bit
			assign r2 = {r_s[k], 1'b0};
			always_comb begin
				if (r2 >= (tw4w_pkg::REM_W+1)'(d_s[k])) begin
					r_n = tw4w_pkg::REM_W'(r2 - (tw4w_pkg::REM_W+1)'(d_s[k]));
					q_n = {q_s[k][tw4w_pkg::Q_W-2:0], 1'b1};
				end else begin
					r_n = r2[tw4w_pkg::REM_W-1:0];
					q_n = {q_s[k][tw4w_pkg::Q_W-2:0], 1'b0};
				end
			end
		end else begin : g_div_pass
			assign r2 = {1'b0, r_s[k]};
			assign r_n = r2[tw4w_pkg::REM_W-1:0];
			assign q_n = q_s[k];
		end

		// hold on stall
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1] <= x_n;
				y_s[k+1] <= y_n;
				z_s[k+1] <= z_n;
				r_s[k+1] <= r_n;
				q_s[k+1] <= q_n;
				d_s[k+1] <= d_s[k];
			end
		end
	end

	assign out_valid = v_s[LEN];
	assign x_out = x_s[LEN];
	assign z_out = z_s[LEN];
	assign quot = q_s[LEN];
	assign rem_nz = (r_s[LEN] != '0);

endmodule

@@ rtl/core/tw4w_checker.sv @@
`include "twist_to_four_wheel_commands_core_defines.svh"

module tw4w_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input tw4w_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input tw4w_pkg::out_t out_data
);
	// a waiting input item stays offered with its payload
	`TW4W_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "input item changed while waiting")

	// a waiting item holds its payload
	`TW4W_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output item changed while stalled")

	// an empty output register never blocks the input
	`TW4W_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with output empty")

	// left and right steer agree on each axle
	`TW4W_ASSERT_IMPL(a_steer_pairs, out_valid, (out_data.steer_front_left == out_data.steer_front_right) && (out_data.steer_rear_left == out_data.steer_rear_right), "steer pair mismatch")

	// rear steer mirrors front when no clamp is involved
	`TW4W_ASSERT_IMPL(a_rear_mirror, out_valid && (out_data.steer_front_left != 24'sh7FFFFF) && (out_data.steer_front_left != 24'sh800000), out_data.steer_rear_left == -out_data.steer_front_left, "rear steer not negated front")

endmodule

bind twist_to_four_wheel_commands_core tw4w_checker u_tw4w_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ sim/twist_checker.sv @@
`timescale 1ns / 100ps

module twist_checker #(
	parameter int CORDIC_STEPS = tw4w_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  tw4w_pkg::in_t                     in_data,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  tw4w_pkg::out_t                    out_data,
	input  logic                              cfg_we,
	input  logic [tw4w_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [tw4w_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                                err_count,
	output int                                pending,
	output int                                seen_count
);
	localparam longint ATAN_Q16 [0:23] = '{
		51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
	};
	localparam int NUM_ROT = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

	string field_names [0:7] = '{
		"velocity_front_left", "velocity_front_right", "velocity_rear_left",
		"velocity_rear_right", "steer_front_left", "steer_front_right",
		"steer_rear_left", "steer_rear_right"
	};

	longint move_thr;
	longint rot_thr;
	longint wheel_radius [0:3];
	tw4w_pkg::out_t wheel_cmd_q [$];

	// clamp to the output range
	function automatic logic [23:0] clamp_q816(longint v);
		if (v > 8388607) return 24'h7FFFFF;
		if (v < -8388608) return 24'h800000;
		return v[23:0];
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// vectoring rotation: magnitude and heading of (x, y)
	function automatic void heading_mag(input longint xi, input longint yi,
			output longint mag, output longint ang);
		longint x, y, z, nx, ny, t;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			ang = 0;
			return;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = tw4w_pkg::HALF_PI_Q16;
			end else begin
				x = -y;
				y = t;
				z = -tw4w_pkg::HALF_PI_Q16;
			end
		end
		for (int i = 0; i < NUM_ROT; i++) begin
			if (y < 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ATAN_Q16[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ATAN_Q16[i];
			end
			x = nx;
			y = ny;
		end
		mag = (x * tw4w_pkg::GAIN_INV + 32768) >>> 16;
		ang = z;
	endfunction

	function automatic tw4w_pkg::out_t predict_wheels(tw4w_pkg::in_t d);
		longint x, y, w, ax, ay, aw, mv, sum, lr, ar, hyp, ang, front;
		longint vel [0:3];
		tw4w_pkg::out_t r;
		x = longint'(d.forward_speed);
		y = longint'(d.lateral_speed);
		w = longint'(d.yaw_rate);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		aw = (w < 0) ? -w : w;
		mv = ax + ay;
		if (mv < move_thr && aw < rot_thr) begin
			for (int i = 0; i < 4; i++) vel[i] = 0;
			front = 0;
		end else if (mv > move_thr && aw > rot_thr) begin
			sum = mv + aw;
			lr = (mv * 65536) / sum;
			ar = (aw * 65536) / sum;
			heading_mag(x, y, hyp, ang);
			for (int i = 0; i < 4; i++)
				vel[i] = round_shift(hyp * lr * 65536 + w * wheel_radius[i] * ar, 32);
			front = round_shift(ang * lr + w * ar, 16);
		end else if (mv > move_thr) begin
			heading_mag(x, y, hyp, ang);
			for (int i = 0; i < 4; i++) vel[i] = hyp;
			front = ang;
		end else begin
			for (int i = 0; i < 4; i++) vel[i] = round_shift(w * wheel_radius[i], 16);
			front = w;
		end
		r.velocity_front_left  = clamp_q816(vel[0]);
		r.velocity_front_right = clamp_q816(vel[1]);
		r.velocity_rear_left   = clamp_q816(vel[2]);
		r.velocity_rear_right  = clamp_q816(vel[3]);
		r.steer_front_left     = clamp_q816(front);
		r.steer_front_right    = clamp_q816(front);
		r.steer_rear_left      = clamp_q816(-front);
		r.steer_rear_right     = clamp_q816(-front);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	initial begin
		err_count = 0;
		seen_count = 0;
		move_thr = 655;
		rot_thr = 655;
		for (int i = 0; i < 4; i++) wheel_radius[i] = 0;
	end

	assign pending = wheel_cmd_q.size();

	// track registers, predict accepted items, compare delivered results
	always @(posedge clk) begin
		tw4w_pkg::out_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_addr)
					tw4w_pkg::REG_MOVE_THR: move_thr = longint'(cfg_wdata);
					tw4w_pkg::REG_ROT_THR:  rot_thr = longint'(cfg_wdata);
					tw4w_pkg::REG_RAD_FL:   wheel_radius[0] = longint'(cfg_wdata[19:0]);
					tw4w_pkg::REG_RAD_FR:   wheel_radius[1] = longint'(cfg_wdata[19:0]);
					tw4w_pkg::REG_RAD_RL:   wheel_radius[2] = longint'(cfg_wdata[19:0]);
					tw4w_pkg::REG_RAD_RR:   wheel_radius[3] = longint'(cfg_wdata[19:0]);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen_count++;
				if (wheel_cmd_q.size() == 0) begin
					report_mismatch("result with no item pending");
				end else begin
					want = wheel_cmd_q.pop_front();
					for (int f = 0; f < 8; f++) begin
						if (out_data[191 - 24*f -: 24] !== want[191 - 24*f -: 24])
							report_mismatch($sformatf("%s got %0d want %0d",
								field_names[f],
								$signed(out_data[191 - 24*f -: 24]),
								$signed(want[191 - 24*f -: 24])));
					end
				end
			end
			if (in_valid && in_ready)
				wheel_cmd_q.push_back(predict_wheels(in_data));
		end
	end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	// indexes with no register behind them
	localparam logic [tw4w_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [tw4w_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tw4w_pkg::in_t  in_data;
	logic out_valid;
	logic out_ready;
	tw4w_pkg::out_t out_data;
	logic cfg_we;
	logic [tw4w_pkg::CFG_IDX_W-1:0]  cfg_addr;
	logic [tw4w_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int   err_count;
	int   pending;
	int   seen_count;
	int   sent_count;
	bit   long_stall_req;

	twist_to_four_wheel_commands_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	twist_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.err_count(err_count), .pending(pending), .seen_count(seen_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#20000000;
		$display("testbench: done, errors");
		$finish;
	end

	// receiver: stall pattern changes at random, long hold-off on request
	initial begin
		int mode;
		int hold;
		out_ready = 1'b0;
		mode = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				hold = 300;
			end
			if ($urandom_range(63, 0) == 0) mode = $urandom_range(2, 0);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(1, 0);
					default: out_ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	// offer one item; returns at the edge where it is taken
	task automatic send_cmd(tw4w_pkg::in_t d);
		in_valid <= 1'b1;
		in_data <= d;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		sent_count++;
	endtask

	// mostly return at once, otherwise drop valid and idle for a random gap
	task automatic idle_gap();
		int n;
		n = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 1) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// drive one write; the caller drops the enable after the last
	task automatic write_reg(logic [tw4w_pkg::CFG_IDX_W-1:0] idx,
			logic [tw4w_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_setup(int mt, int rt, int fl, int fr, int rl, int rr);
		write_reg(tw4w_pkg::REG_MOVE_THR, tw4w_pkg::CFG_DATA_W'(mt));
		write_reg(tw4w_pkg::REG_ROT_THR, tw4w_pkg::CFG_DATA_W'(rt));
		write_reg(tw4w_pkg::REG_RAD_FL, tw4w_pkg::CFG_DATA_W'(fl));
		write_reg(tw4w_pkg::REG_RAD_FR, tw4w_pkg::CFG_DATA_W'(fr));
		write_reg(tw4w_pkg::REG_RAD_RL, tw4w_pkg::CFG_DATA_W'(rl));
		write_reg(tw4w_pkg::REG_RAD_RR, tw4w_pkg::CFG_DATA_W'(rr));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic tw4w_pkg::in_t cmd(int x, int y, int w);
		tw4w_pkg::in_t d;
		d.forward_speed = tw4w_pkg::IN_W'(x);
		d.lateral_speed = tw4w_pkg::IN_W'(y);
		d.yaw_rate = tw4w_pkg::IN_W'(w);
		return d;
	endfunction

	function automatic logic [23:0] rand_field(int thr);
		int k;
		k = $urandom_range(9, 0);
		if (k < 4) return 24'($urandom());
		if (k < 7) return 24'($signed($urandom_range(8192, 0)) - 4096);
		if (k == 7) return ($urandom_range(1, 0)) ? 24'(thr) : -24'(thr);
		if (k == 8) return ($urandom_range(1, 0)) ? 24'h7FFFFF : 24'h800000;
		return 24'd0;
	endfunction

	initial begin
		int mt, rt, burst;
		tw4w_pkg::in_t d;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		sent_count = 0;
		long_stall_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, quadrants, thresholds, saturation
		load_setup(655, 655, 20'h10000, 20'h18000, 20'hFFFFF, 20'h0);
		write_reg(REG_SPARE_A, 23'h7FFFFF);
		write_reg(REG_SPARE_B, 23'h1234);
		cfg_we <= 1'b0;
		send_cmd(cmd(0, 0, 0));
		send_cmd(cmd(100, 100, 100));
		send_cmd(cmd(655, 0, 0));
		send_cmd(cmd(0, 0, 655));
		send_cmd(cmd(0, 0, -655));
		send_cmd(cmd(656, 0, 0));
		send_cmd(cmd(0, -656, 0));
		send_cmd(cmd(0, 0, 656));
		send_cmd(cmd(655, 0, 700));
		send_cmd(cmd(8388607, 8388607, 0));
		send_cmd(cmd(-8388608, -8388608, 0));
		send_cmd(cmd(-8388608, 0, 0));
		send_cmd(cmd(-65536, 65536, 0));
		send_cmd(cmd(-65536, -65536, 0));
		send_cmd(cmd(65536, -65536, 0));
		send_cmd(cmd(0, 0, -8388608));
		send_cmd(cmd(0, 0, 8388607));
		send_cmd(cmd(65536, 32768, 65536));
		send_cmd(cmd(-8388608, 8388607, -8388608));
		send_cmd(cmd(8388607, -8388608, 8388607));
		send_cmd(cmd(-1, -1, -1));
		drain();

		// random phases, each under its own register setup
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin mt = 0; rt = 0; end
				1: begin mt = 8388607; rt = 8388607; end
				2: begin mt = 655; rt = 655; end
				default: begin
					mt = $urandom_range(5000, 0);
					rt = $urandom_range(5000, 0);
				end
			endcase
			if (ph == 0)
				load_setup(mt, rt, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
			else if (ph == 1)
				load_setup(mt, rt, 0, 0, 0, 0);
			else
				load_setup(mt, rt, $urandom_range(20'hFFFFF, 0), $urandom_range(20'hFFFFF, 0),
					$urandom_range(20'h3FFFF, 0), $urandom_range(20'h3FFFF, 0));
			burst = 0;
			for (int n = 0; n < 123; n++) begin
				d.forward_speed = rand_field(mt);
				d.lateral_speed = ($urandom_range(3, 0) == 0) ? 24'd0 : rand_field(mt);
				d.yaw_rate = rand_field(rt);
				// long receiver hold-off while items keep coming
				if (n == 40 && ph % 3 == 0) long_stall_req = 1'b1;
				// let everything drain mid-phase once in a while
				if (n == 80 && ph % 4 == 1) drain();
				send_cmd(d);
				if (burst == 0) begin
					idle_gap();
					burst = $urandom_range(20, 1);
				end else begin
					burst--;
				end
			end
			drain();
		end

		$display("run covered %0d commands and %0d results over 11 register setups",
			sent_count, seen_count);
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule
